// File: rtl/core/gdn_pkg.sv
`default_nettype none

package gdn_pkg;

    localparam int DN_W    = 22;
    localparam int SN_W    = 23;
    localparam int MS_W    = 27;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MSEC_W  = 10;

    // Year and day-of-year inside the date pipeline.
    localparam int YQ_W    = 15;
    localparam int Q100_W  = 9;
    localparam int DBY_W   = 24;
    localparam int DOY_W   = 9;

    localparam logic ACT_DECODE = 1'b0;
    localparam logic ACT_ENCODE = 1'b1;

    localparam logic [MS_W-1:0] MS_PER_DAY = 27'd86400000;

    // floor(2^32 * 2000 / 730485); the estimate is never above the true year.
    localparam logic [23:0] YEAR_RECIP = 24'd11759221;
    localparam logic [19:0] YEAR_DIV   = 20'd730485;

    // ceil(2^37 / 1000), exact for any 27-bit millisecond count.
    localparam logic [27:0] MSEC_RECIP = 28'd137438954;

    localparam int CIVIL_STAGES = 6;
    localparam int TOD_STAGES   = 4;
    localparam int TOD_DLY      = CIVIL_STAGES - TOD_STAGES;

    typedef struct packed {
        logic                 action;
        logic                 wrap;
        logic                 enc_bad;
        logic [SN_W-1:0]      sn;
        logic [MS_W-1:0]      ms;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
    } front_t;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
    } civ_t;

    typedef struct packed {
        logic [HOUR_W-1:0]    hours;
        logic [MIN_W-1:0]     minutes;
        logic [SEC_W-1:0]     seconds;
        logic [MSEC_W-1:0]    millis;
    } tod_t;

    // Days from 1 March to the first day of each month of the March-based year.
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mi);
        logic [DOY_W-1:0] d;
        case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // y / 100 by reciprocal, exact for every 15-bit value.
    function automatic logic [Q100_W-1:0] div100(input logic [YQ_W-1:0] y);
        logic [27:0] prod;
        prod = {13'd0, y} * 28'd5243;
        return prod[27:19];
    endfunction

    // 365*y + y/4 - y/100 + y/400, with q = y/100 already known.
    function automatic logic [DBY_W-1:0] days_before(input logic [YQ_W-1:0]   y,
                                                     input logic [Q100_W-1:0] q);
        return DBY_W'(y) * 24'd365 + DBY_W'(y >> 2) - DBY_W'(q) + DBY_W'(q >> 2);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/gdn_front.sv
`default_nettype none

module gdn_front (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         action,
    input  wire  [21:0] in_day_number,
    input  wire  [26:0] in_millis_of_day,
    input  wire  [13:0] in_year,
    input  wire  [3:0]  in_month,
    input  wire  [4:0]  in_day,
    input  wire  [4:0]  in_hours,
    input  wire  [5:0]  in_minutes,
    input  wire  [5:0]  in_seconds,
    input  wire  [9:0]  in_millis,
    output logic            fr_valid,
    output gdn_pkg::front_t fr
);
    import gdn_pkg::*;

    // First stage: decode carry, encode month shift and year/100.
    logic                wrap_next;
    logic [MS_W-1:0]     ms_dec_next;
    logic [SN_W-1:0]     sn_dec_next;
    logic [MONTH_W-1:0]  m_next;
    logic                late_next;
    logic                under_next;
    logic [YEAR_W-1:0]   y_enc_next;
    logic [Q100_W-1:0]   q100_next;
    logic [DOY_W-1:0]    off_next;
    logic                time_bad_next;

    logic                s1_valid_reg;
    logic                action_reg;
    logic                wrap_reg;
    logic [MS_W-1:0]     ms_dec_reg;
    logic [SN_W-1:0]     sn_dec_reg;
    logic                under_reg;
    logic [YEAR_W-1:0]   y_enc_reg;
    logic [Q100_W-1:0]   q100_reg;
    logic [DOY_W-1:0]    off_reg;
    logic                time_bad_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hours_reg;
    logic [MIN_W-1:0]    minutes_reg;
    logic [SEC_W-1:0]    seconds_reg;
    logic [MSEC_W-1:0]   millis_reg;

    // Second stage: day count of the encoded date and millisecond of the day.
    logic [DBY_W-1:0]    sum_next;
    logic [DBY_W-1:0]    dn_next;
    logic                neg_next;
    logic                over_next;
    logic [MS_W-1:0]     ms_enc_next;
    front_t              fr_next;

    logic                fr_valid_reg;
    front_t              fr_reg;

    always_comb
    begin
        wrap_next   = in_millis_of_day >= MS_PER_DAY;
        ms_dec_next = wrap_next ? in_millis_of_day - MS_PER_DAY : in_millis_of_day;
        sn_dec_next = {1'b0, in_day_number} + SN_W'(wrap_next);

        case (in_month) inside
            [4'd0:4'd2]: m_next = in_month + 4'd9;
            4'd15:       m_next = 4'd0;
            default:     m_next = in_month - 4'd3;
        endcase

        // January and February count as the end of the previous year.
        late_next     = m_next >= 4'd10;
        under_next    = (in_year == '0) && late_next;
        y_enc_next    = in_year - YEAR_W'(late_next);
        q100_next     = div100({1'b0, y_enc_next});
        off_next      = month_start(m_next);
        time_bad_next = (in_hours >= 5'd24) || (in_minutes >= 6'd60) ||
                        (in_seconds >= 6'd60) || (in_millis >= 10'd1000);
    end

    always_comb
    begin
        sum_next  = days_before({1'b0, y_enc_reg}, q100_reg) + DBY_W'(off_reg) +
                    DBY_W'(day_reg);
        dn_next   = sum_next - 24'd1;
        neg_next  = sum_next == '0;
        over_next = dn_next[DBY_W-1:DN_W] != '0;
        ms_enc_next = MS_W'(hours_reg) * 27'd3600000 + MS_W'(minutes_reg) * 27'd60000 +
                      MS_W'(seconds_reg) * 27'd1000 + MS_W'(millis_reg);

        fr_next.action  = action_reg;
        fr_next.wrap    = wrap_reg && (action_reg == ACT_DECODE);
        fr_next.enc_bad = time_bad_reg || under_reg || neg_next || over_next;
        fr_next.sn      = (action_reg == ACT_ENCODE) ? dn_next[SN_W-1:0] : sn_dec_reg;
        fr_next.ms      = (action_reg == ACT_ENCODE) ? ms_enc_next : ms_dec_reg;
        fr_next.year    = year_reg;
        fr_next.month   = month_reg;
        fr_next.day     = day_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            fr_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action;
        wrap_reg     <= wrap_next;
        ms_dec_reg   <= ms_dec_next;
        sn_dec_reg   <= sn_dec_next;
        under_reg    <= under_next;
        y_enc_reg    <= y_enc_next;
        q100_reg     <= q100_next;
        off_reg      <= off_next;
        time_bad_reg <= time_bad_next;
        year_reg     <= in_year;
        month_reg    <= in_month;
        day_reg      <= in_day;
        hours_reg    <= in_hours;
        minutes_reg  <= in_minutes;
        seconds_reg  <= in_seconds;
        millis_reg   <= in_millis;
        fr_reg       <= fr_next;
    end

    assign fr_valid = fr_valid_reg;
    assign fr       = fr_reg;

endmodule

`default_nettype wire

// File: rtl/core/gdn_civil.sv
`default_nettype none

module gdn_civil (
    input  wire         clk,
    input  wire  [22:0] sn,
    output gdn_pkg::civ_t civ
);
    import gdn_pkg::*;

    logic [46:0]         prod1_next;
    logic [YQ_W-1:0]     q0_c1_reg;
    logic [SN_W-1:0]     sn_c1_reg;

    logic [34:0]         p_next;
    logic [33:0]         np_next;
    logic [34:0]         p_c2_reg;
    logic [33:0]         np_c2_reg;
    logic [YQ_W-1:0]     q0_c2_reg;
    logic [SN_W-1:0]     sn_c2_reg;

    logic [34:0]         r_next;
    logic [YQ_W-1:0]     y_c3_next;
    logic [YQ_W-1:0]     y_c3_reg;
    logic [SN_W-1:0]     sn_c3_reg;

    logic [YQ_W-1:0]     ym1_next;
    logic [YQ_W-1:0]     y_c4_reg;
    logic [YQ_W-1:0]     ym1_c4_reg;
    logic [Q100_W-1:0]   qa_c4_reg;
    logic [Q100_W-1:0]   qb_c4_reg;
    logic [SN_W-1:0]     sn_c4_reg;

    logic [24:0]         diff0_next;
    logic [24:0]         diff1_next;
    logic [YQ_W-1:0]     y_c5_next;
    logic [DOY_W-1:0]    doy_c5_next;
    logic [YQ_W-1:0]     y_c5_reg;
    logic [DOY_W-1:0]    doy_c5_reg;

    logic [MONTH_W-1:0]  mi_next;
    logic [YQ_W-1:0]     year_next;
    logic [DOY_W-1:0]    day_next;
    civ_t                civ_next;
    civ_t                civ_reg;

    // Year estimate from below; the true year is this or one more.
    assign prod1_next = 47'(sn) * 47'(YEAR_RECIP);

    assign p_next  = 35'(q0_c1_reg) * 35'(YEAR_DIV);
    assign np_next = 34'(sn_c1_reg) * 34'd2000 + 34'd2956;

    assign r_next    = 35'(np_c2_reg) - p_c2_reg;
    assign y_c3_next = q0_c2_reg + YQ_W'(r_next >= 35'(YEAR_DIV));

    assign ym1_next = y_c3_reg - 15'd1;

    always_comb
    begin
        diff0_next = 25'(sn_c4_reg) - 25'(days_before(y_c4_reg, qa_c4_reg));
        diff1_next = 25'(sn_c4_reg) - 25'(days_before(ym1_c4_reg, qb_c4_reg));
        // A negative day of year means the estimate ran one year ahead.
        if (diff0_next[24])
        begin
            y_c5_next   = ym1_c4_reg;
            doy_c5_next = diff1_next[DOY_W-1:0];
        end
        else
        begin
            y_c5_next   = y_c4_reg;
            doy_c5_next = diff0_next[DOY_W-1:0];
        end
    end

    always_comb
    begin
        mi_next = '0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy_c5_reg >= month_start(MONTH_W'(k)))
            begin
                mi_next = MONTH_W'(k);
            end
        end
        year_next = y_c5_reg + YQ_W'(mi_next >= 4'd10);
        day_next  = doy_c5_reg - month_start(mi_next) + 9'd1;

        civ_next.year  = year_next[YEAR_W-1:0];
        civ_next.month = (mi_next < 4'd10) ? mi_next + 4'd3 : mi_next - 4'd9;
        civ_next.day   = day_next[DAY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        q0_c1_reg  <= prod1_next[46:32];
        sn_c1_reg  <= sn;
        p_c2_reg   <= p_next;
        np_c2_reg  <= np_next;
        q0_c2_reg  <= q0_c1_reg;
        sn_c2_reg  <= sn_c1_reg;
        y_c3_reg   <= y_c3_next;
        sn_c3_reg  <= sn_c2_reg;
        y_c4_reg   <= y_c3_reg;
        ym1_c4_reg <= ym1_next;
        qa_c4_reg  <= div100(y_c3_reg);
        qb_c4_reg  <= div100(ym1_next);
        sn_c4_reg  <= sn_c3_reg;
        y_c5_reg   <= y_c5_next;
        doy_c5_reg <= doy_c5_next;
        civ_reg    <= civ_next;
    end

    assign civ = civ_reg;

endmodule

`default_nettype wire

// File: rtl/core/gdn_tod.sv
`default_nettype none

module gdn_tod (
    input  wire         clk,
    input  wire  [26:0] ms,
    output gdn_pkg::tod_t tod
);
    import gdn_pkg::*;

    logic [54:0]        tprod_next;
    logic [16:0]        t1_reg;
    logic [MS_W-1:0]    ms1_reg;

    logic [MS_W-1:0]    ml_next;
    logic [34:0]        uprod_next;
    logic [16:0]        t2_reg;
    logic [MSEC_W-1:0]  ml2_reg;
    logic [10:0]        u2_reg;

    logic [16:0]        s_next;
    logic [21:0]        hprod_next;
    logic [MSEC_W-1:0]  ml3_reg;
    logic [SEC_W-1:0]   s3_reg;
    logic [10:0]        u3_reg;
    logic [HOUR_W-1:0]  h3_reg;

    logic [10:0]        mi_next;
    tod_t               tod_reg;

    // Seconds of the day, then minutes of the day, then hours.
    assign tprod_next = 55'(ms) * 55'(MSEC_RECIP);

    assign ml_next    = ms1_reg - 27'(t1_reg) * 27'd1000;
    assign uprod_next = 35'(t1_reg) * 35'd139811;

    assign s_next     = t2_reg - 17'(u2_reg) * 17'd60;
    assign hprod_next = 22'(u2_reg) * 22'd1093;

    assign mi_next    = u3_reg - 11'(h3_reg) * 11'd60;

    always_ff @(posedge clk)
    begin
        t1_reg          <= tprod_next[53:37];
        ms1_reg         <= ms;
        t2_reg          <= t1_reg;
        ml2_reg         <= ml_next[MSEC_W-1:0];
        u2_reg          <= uprod_next[33:23];
        ml3_reg         <= ml2_reg;
        s3_reg          <= s_next[SEC_W-1:0];
        u3_reg          <= u2_reg;
        h3_reg          <= hprod_next[20:16];
        tod_reg.hours   <= h3_reg;
        tod_reg.minutes <= mi_next[MIN_W-1:0];
        tod_reg.seconds <= s3_reg;
        tod_reg.millis  <= ml3_reg;
    end

    assign tod = tod_reg;

endmodule

`default_nettype wire

// File: rtl/core/gregorian_day_number_converter.sv
`default_nettype none

// Converts between a day count from 1 March of year 0 plus a millisecond of the day and a
// calendar date with a time of day. The block is a nine-stage pipeline: it takes a new item
// in every clock cycle, busy stays low, and the result of an item appears on the outputs
// with done high from the output registers. Results come out in
// the order the items went in and are shown for exactly one cycle, so the receiver must take
// them as they come. Most of the latency is the date path, which estimates the year with a
// reciprocal multiply, corrects it by one step and then finds the month by comparison.
module gregorian_day_number_converter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         action,
    input  wire  [21:0] in_day_number,
    input  wire  [26:0] in_millis_of_day,
    input  wire  [13:0] in_year,
    input  wire  [3:0]  in_month,
    input  wire  [4:0]  in_day,
    input  wire  [4:0]  in_hours,
    input  wire  [5:0]  in_minutes,
    input  wire  [5:0]  in_seconds,
    input  wire  [9:0]  in_millis,
    output logic        done,
    output logic [21:0] out_day_number,
    output logic [26:0] out_millis_of_day,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hours,
    output logic [5:0]  out_minutes,
    output logic [5:0]  out_seconds,
    output logic [9:0]  out_millis,
    output logic        invalid
);
    import gdn_pkg::*;

    logic               fr_valid;
    front_t             fr;
    civ_t               civ;
    tod_t               tod;

    logic               vld_reg  [CIVIL_STAGES];
    front_t             side_reg [CIVIL_STAGES];
    tod_t               tod_dly_reg [TOD_DLY];

    front_t             last;
    tod_t               tod_last;
    logic               match;
    logic               zero_out;

    logic               done_reg;
    logic [DN_W-1:0]    day_number_reg;
    logic [MS_W-1:0]    millis_of_day_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [HOUR_W-1:0]  hours_reg;
    logic [MIN_W-1:0]   minutes_reg;
    logic [SEC_W-1:0]   seconds_reg;
    logic [MSEC_W-1:0]  millis_reg;
    logic               invalid_reg;

    assign busy = 1'b0;

    gdn_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .action           (action),
        .in_day_number    (in_day_number),
        .in_millis_of_day (in_millis_of_day),
        .in_year          (in_year),
        .in_month         (in_month),
        .in_day           (in_day),
        .in_hours         (in_hours),
        .in_minutes       (in_minutes),
        .in_seconds       (in_seconds),
        .in_millis        (in_millis),
        .fr_valid         (fr_valid),
        .fr               (fr)
    );

    gdn_civil u_civil (
        .clk (clk),
        .sn  (fr.sn),
        .civ (civ)
    );

    gdn_tod u_tod (
        .clk (clk),
        .ms  (fr.ms),
        .tod (tod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CIVIL_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= fr_valid;
            for (int i = 1; i < CIVIL_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            done_reg <= vld_reg[CIVIL_STAGES-1];
        end
    end

    // The item's own fields ride alongside the date pipeline; the time split is shorter
    // and is delayed to meet it.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= fr;
        for (int i = 1; i < CIVIL_STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        tod_dly_reg[0] <= tod;
        for (int i = 1; i < TOD_DLY; i++)
        begin
            tod_dly_reg[i] <= tod_dly_reg[i-1];
        end
    end

    always_comb
    begin
        last     = side_reg[CIVIL_STAGES-1];
        tod_last = tod_dly_reg[TOD_DLY-1];
        // An encoded date is good only if it decodes back to what was given.
        match    = !last.enc_bad && (civ.year == last.year) &&
                   (civ.month == last.month) && (civ.day == last.day);
        zero_out = (last.action == ACT_ENCODE) && !match;
    end

    always_ff @(posedge clk)
    begin
        if (zero_out)
        begin
            day_number_reg    <= '0;
            millis_of_day_reg <= '0;
            year_reg          <= '0;
            month_reg         <= '0;
            day_reg           <= '0;
            hours_reg         <= '0;
            minutes_reg       <= '0;
            seconds_reg       <= '0;
            millis_reg        <= '0;
            invalid_reg       <= 1'b1;
        end
        else
        begin
            day_number_reg    <= last.sn[DN_W-1:0];
            millis_of_day_reg <= last.ms;
            year_reg          <= civ.year;
            month_reg         <= civ.month;
            day_reg           <= civ.day;
            hours_reg         <= tod_last.hours;
            minutes_reg       <= tod_last.minutes;
            seconds_reg       <= tod_last.seconds;
            millis_reg        <= tod_last.millis;
            invalid_reg       <= last.wrap;
        end
    end

    assign done              = done_reg;
    assign out_day_number    = day_number_reg;
    assign out_millis_of_day = millis_of_day_reg;
    assign out_year          = year_reg;
    assign out_month         = month_reg;
    assign out_day           = day_reg;
    assign out_hours         = hours_reg;
    assign out_minutes       = minutes_reg;
    assign out_seconds       = seconds_reg;
    assign out_millis        = millis_reg;
    assign invalid           = invalid_reg;

endmodule

`default_nettype wire

// File: tb/gdn_checker.sv
`default_nettype none

module gdn_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire         action,
    input  wire  [21:0] in_day_number,
    input  wire  [26:0] in_millis_of_day,
    input  wire  [13:0] in_year,
    input  wire  [3:0]  in_month,
    input  wire  [4:0]  in_day,
    input  wire  [4:0]  in_hours,
    input  wire  [5:0]  in_minutes,
    input  wire  [5:0]  in_seconds,
    input  wire  [9:0]  in_millis,
    input  wire         done,
    input  wire  [21:0] out_day_number,
    input  wire  [26:0] out_millis_of_day,
    input  wire  [13:0] out_year,
    input  wire  [3:0]  out_month,
    input  wire  [4:0]  out_day,
    input  wire  [4:0]  out_hours,
    input  wire  [5:0]  out_minutes,
    input  wire  [5:0]  out_seconds,
    input  wire  [9:0]  out_millis,
    input  wire         invalid,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DAY_MS = longint'(gdn_pkg::MS_PER_DAY);
    localparam longint DN_MAX = (longint'(1) << gdn_pkg::DN_W) - 1;

    typedef struct packed {
        logic [gdn_pkg::DN_W-1:0]    day_number;
        logic [gdn_pkg::MS_W-1:0]    millis_of_day;
        logic [gdn_pkg::YEAR_W-1:0]  year;
        logic [gdn_pkg::MONTH_W-1:0] month;
        logic [gdn_pkg::DAY_W-1:0]   day;
        logic [gdn_pkg::HOUR_W-1:0]  hours;
        logic [gdn_pkg::MIN_W-1:0]   minutes;
        logic [gdn_pkg::SEC_W-1:0]   seconds;
        logic [gdn_pkg::MSEC_W-1:0]  millis;
        logic                        bad;
    } conversion_t;

    conversion_t conversions_due[$];

    function automatic longint days_before_year(input longint y);
        return 365 * y + y / 4 - y / 100 + y / 400;
    endfunction

    // The year estimate is never more than one too high, so a single step back fixes it.
    function automatic void civil_date(input longint dn, output longint yr,
                                       output longint mo, output longint dy);
        longint y;
        longint doy;
        longint mi;
        y = (10000 * dn + 14780) / 3652425;
        doy = dn - days_before_year(y);
        if (doy < 0)
        begin
            y = y - 1;
            doy = dn - days_before_year(y);
        end
        mi = (100 * doy + 52) / 3060;
        mo = (mi + 2) % 12 + 1;
        yr = y + (mi + 2) / 12;
        dy = doy - (mi * 306 + 5) / 10 + 1;
    endfunction

    function automatic conversion_t pack_conversion(input longint dn, input longint ms,
                                                    input logic bad);
        conversion_t r;
        longint yr;
        longint mo;
        longint dy;
        longint hh;
        longint mn;
        longint ss;
        longint ml;
        civil_date(dn, yr, mo, dy);
        hh = ms / 3600000;
        mn = (ms / 60000) % 60;
        ss = (ms / 1000) % 60;
        ml = ms % 1000;
        r.day_number    = dn[gdn_pkg::DN_W-1:0];
        r.millis_of_day = ms[gdn_pkg::MS_W-1:0];
        r.year          = yr[gdn_pkg::YEAR_W-1:0];
        r.month         = mo[gdn_pkg::MONTH_W-1:0];
        r.day           = dy[gdn_pkg::DAY_W-1:0];
        r.hours         = hh[gdn_pkg::HOUR_W-1:0];
        r.minutes       = mn[gdn_pkg::MIN_W-1:0];
        r.seconds       = ss[gdn_pkg::SEC_W-1:0];
        r.millis        = ml[gdn_pkg::MSEC_W-1:0];
        r.bad           = bad;
        return r;
    endfunction

    function automatic conversion_t expected_conversion();
        conversion_t r;
        longint dn;
        longint ms;
        longint m;
        longint y;
        longint ry;
        longint rm;
        longint rd;
        if (action == gdn_pkg::ACT_DECODE)
        begin
            dn = longint'(in_day_number);
            ms = longint'(in_millis_of_day);
            // A full day or more of milliseconds rolls over into the next day and is flagged.
            if (ms >= DAY_MS)
                return pack_conversion(dn + 1, ms - DAY_MS, 1'b1);
            return pack_conversion(dn, ms, 1'b0);
        end
        r = '0;
        r.bad = 1'b1;
        if (in_hours >= 24 || in_minutes >= 60 || in_seconds >= 60 || in_millis >= 1000)
            return r;
        m = (longint'(in_month) + 9) % 12;
        y = longint'(in_year) - m / 10;
        dn = days_before_year(y) + (m * 306 + 5) / 10 + longint'(in_day) - 1;
        if (dn < 0 || dn > DN_MAX)
            return r;
        // The date must survive a round trip through the decoder.
        civil_date(dn, ry, rm, rd);
        if (ry != longint'(in_year) || rm != longint'(in_month) || rd != longint'(in_day))
            return r;
        ms = longint'(in_hours) * 3600000 + longint'(in_minutes) * 60000
           + longint'(in_seconds) * 1000 + longint'(in_millis);
        return pack_conversion(dn, ms, 1'b0);
    endfunction

    function automatic string show(input conversion_t c);
        return $sformatf("day %0d ms %0d date %0d-%0d-%0d time %0d:%0d:%0d.%0d invalid %0b",
                         c.day_number, c.millis_of_day, c.year, c.month, c.day,
                         c.hours, c.minutes, c.seconds, c.millis, c.bad);
    endfunction

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        conversion_t want;
        conversion_t got;
        string diff;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                got = {out_day_number, out_millis_of_day, out_year, out_month, out_day,
                       out_hours, out_minutes, out_seconds, out_millis, invalid};
                if (conversions_due.size() == 0)
                    note_failure($sformatf("result with no item waiting: %s", show(got)));
                else
                begin
                    want = conversions_due.pop_front();
                    diff = "";
                    if (got.day_number !== want.day_number)       diff = {diff, " day_number"};
                    if (got.millis_of_day !== want.millis_of_day) diff = {diff, " millis_of_day"};
                    if (got.year !== want.year)                   diff = {diff, " year"};
                    if (got.month !== want.month)                 diff = {diff, " month"};
                    if (got.day !== want.day)                     diff = {diff, " day"};
                    if (got.hours !== want.hours)                 diff = {diff, " hours"};
                    if (got.minutes !== want.minutes)             diff = {diff, " minutes"};
                    if (got.seconds !== want.seconds)             diff = {diff, " seconds"};
                    if (got.millis !== want.millis)               diff = {diff, " millis"};
                    if (got.bad !== want.bad)                     diff = {diff, " invalid"};
                    if (diff != "")
                        note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                                               diff, show(want), show(got)));
                end
            end
            else if (done !== 1'b0)
                note_failure("done is unknown");
            if (start === 1'b1 && busy === 1'b0)
                conversions_due.push_back(expected_conversion());
            outstanding <= conversions_due.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        action = gdn_pkg::ACT_DECODE;
    logic [21:0] in_day_number = '0;
    logic [26:0] in_millis_of_day = '0;
    logic [13:0] in_year = '0;
    logic [3:0]  in_month = '0;
    logic [4:0]  in_day = '0;
    logic [4:0]  in_hours = '0;
    logic [5:0]  in_minutes = '0;
    logic [5:0]  in_seconds = '0;
    logic [9:0]  in_millis = '0;

    wire         busy;
    wire         done;
    wire  [21:0] out_day_number;
    wire  [26:0] out_millis_of_day;
    wire  [13:0] out_year;
    wire  [3:0]  out_month;
    wire  [4:0]  out_day;
    wire  [4:0]  out_hours;
    wire  [5:0]  out_minutes;
    wire  [5:0]  out_seconds;
    wire  [9:0]  out_millis;
    wire         invalid;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    bit steady = 1'b0;

    always #2 clk = ~clk;

    gregorian_day_number_converter u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .in_day_number     (in_day_number),
        .in_millis_of_day  (in_millis_of_day),
        .in_year           (in_year),
        .in_month          (in_month),
        .in_day            (in_day),
        .in_hours          (in_hours),
        .in_minutes        (in_minutes),
        .in_seconds        (in_seconds),
        .in_millis         (in_millis),
        .done              (done),
        .out_day_number    (out_day_number),
        .out_millis_of_day (out_millis_of_day),
        .out_year          (out_year),
        .out_month         (out_month),
        .out_day           (out_day),
        .out_hours         (out_hours),
        .out_minutes       (out_minutes),
        .out_seconds       (out_seconds),
        .out_millis        (out_millis),
        .invalid           (invalid)
    );

    gdn_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .in_day_number     (in_day_number),
        .in_millis_of_day  (in_millis_of_day),
        .in_year           (in_year),
        .in_month          (in_month),
        .in_day            (in_day),
        .in_hours          (in_hours),
        .in_minutes        (in_minutes),
        .in_seconds        (in_seconds),
        .in_millis         (in_millis),
        .done              (done),
        .out_day_number    (out_day_number),
        .out_millis_of_day (out_millis_of_day),
        .out_year          (out_year),
        .out_month         (out_month),
        .out_day           (out_day),
        .out_hours         (out_hours),
        .out_minutes       (out_minutes),
        .out_seconds       (out_seconds),
        .out_millis        (out_millis),
        .invalid           (invalid),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    // Presents one item, after random idle cycles unless steady is set; returns once taken.
    task automatic issue(input logic act, input int unsigned dn, input int unsigned ms,
                         input int unsigned yr, input int unsigned mo, input int unsigned dy,
                         input int unsigned hh, input int unsigned mn, input int unsigned ss,
                         input int unsigned ml);
        while (!steady && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start            <= 1'b1;
        action           <= act;
        in_day_number    <= dn[21:0];
        in_millis_of_day <= ms[26:0];
        in_year          <= yr[13:0];
        in_month         <= mo[3:0];
        in_day           <= dy[4:0];
        in_hours         <= hh[4:0];
        in_minutes       <= mn[5:0];
        in_seconds       <= ss[5:0];
        in_millis        <= ml[9:0];
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned dn;
        int unsigned ms;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned hh;
        int unsigned mn;
        int unsigned ss;
        int unsigned ml;
        int unsigned roll;
        int unsigned pick;
        logic act;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decode: both ends of the range and rollover of a full day of milliseconds,
        // including rollover past the top of the day count.
        issue(gdn_pkg::ACT_DECODE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_DECODE, 3652364, 86399999, 0, 0, 0, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_DECODE, 4194303, 86400000, 0, 0, 0, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_DECODE, 4194303, 134217727, 0, 0, 0, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_DECODE, 1234567, 86400000, 0, 0, 0, 0, 0, 0, 0);

        // Encode: year 0 from March, negative day counts, leap days, bad months and days,
        // out-of-range time fields and day counts too wide for the result.
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 0, 3, 1, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 0, 1, 1, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 0, 2, 29, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 9999, 12, 31, 23, 59, 59, 999);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2000, 2, 29, 12, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 1900, 2, 29, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2001, 2, 29, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 4, 31, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 1, 0, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 0, 15, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 13, 15, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 15, 15, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 16383, 12, 31, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 11483, 1, 1, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 11484, 1, 1, 0, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 6, 15, 24, 0, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 6, 15, 31, 63, 63, 1023);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 6, 15, 23, 60, 0, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 6, 15, 23, 59, 60, 0);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 6, 15, 23, 59, 59, 1000);
        issue(gdn_pkg::ACT_ENCODE, 0, 0, 2024, 1, 31, 0, 0, 0, 0);

        for (int n = 0; n < 600; n++)
        begin
            steady = (n >= 250 && n < 350);
            roll = $urandom_range(99);
            act = (roll < 30) ? gdn_pkg::ACT_DECODE : gdn_pkg::ACT_ENCODE;
            dn = ($urandom_range(99) < 85) ? $urandom_range(3652364, 0) : $urandom;
            pick = $urandom_range(9);
            if (pick < 8)
                ms = $urandom_range(86399999, 0);
            else if (pick == 8)
                ms = $urandom;
            else
                ms = $urandom_range(86401000, 86399000);
            yr = $urandom;
            mo = $urandom;
            dy = $urandom;
            hh = $urandom;
            mn = $urandom;
            ss = $urandom;
            ml = $urandom;
            // Most encode items are proper dates and times; the rest stay as raw noise.
            if (act == gdn_pkg::ACT_ENCODE && $urandom_range(99) < 75)
            begin
                pick = $urandom_range(9);
                if (pick < 8)
                    yr = $urandom_range(9999, 1);
                else if (pick == 8)
                    yr = $urandom_range(3, 0);
                else
                    yr = $urandom_range(11486, 11480);
                mo = $urandom_range(12, 1);
                dy = ($urandom_range(99) < 70) ? $urandom_range(28, 1) : $urandom_range(31, 28);
                hh = $urandom_range(23, 0);
                mn = $urandom_range(59, 0);
                ss = $urandom_range(59, 0);
                ml = $urandom_range(999, 0);
            end
            issue(act, dn, ms, yr, mo, dy, hh, mn, ss, ml);
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: gregorian_day_number_converter.f
rtl/core/gdn_pkg.sv
rtl/core/gdn_front.sv
rtl/core/gdn_civil.sv
rtl/core/gdn_tod.sv
rtl/core/gregorian_day_number_converter.sv
tb/gdn_checker.sv
tb/testbench.sv
